/* rtl/lpco_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lpco_pkg;
  localparam int MaxTasksDef = 64;
  localparam int IdW = 6;
  localparam int MinW = 11;
  // Entry of the task table
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [MinW-1:0] start;
    logic [MinW-1:0] dur;
  } task_t;
  // Entry of the paused stack
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [MinW-1:0] remain;
  } paused_t;
  typedef struct packed {
    logic [IdW-1:0] id;
    logic           last;
  } done_t;
  typedef struct packed {
    logic [IdW-1:0]  task_id;
    logic [MinW-1:0] start_minute;
    logic [MinW-1:0] duration;
    logic            last_task;
  } item_t;
endpackage
`default_nettype wire

/* rtl/lpco_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lpco_in_if import lpco_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpco_out_if import lpco_pkg::*; ();
  logic  valid;
  logic  ready;
  done_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lifo_preemptive_completion_order_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load: one task transfer per cycle; the task flagged last starts the run and
// no further task is taken until the whole set has been transferred out.
// Sort: insertion sort over the table, shifting later-starting entries up one place.
// Schedule: each task is read with its successor, paused tasks are resumed from the stack
// top, the stack is drained, and each completion transfer is held while out_ch.ready is low.
// Synchronous reset clears control state only; the memories hold no reset value.
module lifo_preemptive_completion_order_top import lpco_pkg::*; #(
  parameter int MAX_TASKS = MaxTasksDef
) (
  input  wire       clk,
  input  wire       rst,
  lpco_in_if.sink   in_ch,
  lpco_out_if.source out_ch
);
  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_SRD, S_SCUR, S_SCMP, S_RRD, S_RCUR, S_RNX, S_REVAL,
    S_RPOP, S_RCHK, S_EMIT, S_DRD, S_DCHK
  } state_t;

  state_t state, ret;
  task_t tmem [MAX_TASKS];
  paused_t pmem [MAX_TASKS];
  task_t trd, cur, tnext;
  paused_t prd;
  logic [AW-1:0] traddr;
  logic [AW-1:0] praddr;
  logic [CW-1:0] count, idx, j, depth;
  logic [CW-1:0] ip1, im1, jm1, jm2, dm1;
  logic [MinW-1:0] spare;
  logic [IdW-1:0] eid;
  logic elast;
  logic obuf_v;
  done_t obuf;
  logic t_we, p_we;
  logic [AW-1:0] t_wa, p_wa;
  task_t t_wd;
  paused_t p_wd;
  logic shift, last_i, emit_go;

  // Synchronous memories with registered read data
  always_ff @(posedge clk) begin
    if (t_we) tmem[t_wa] <= t_wd;
    trd <= tmem[traddr];
    if (p_we) pmem[p_wa] <= p_wd;
    prd <= pmem[praddr];
  end

  logic in_xfer;
  assign in_ch.ready = (state == S_LOAD);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_ch.valid = obuf_v;
  assign out_ch.data = obuf;

  logic [MinW-1:0] gap;
  assign gap = tnext.start - cur.start;

  assign ip1 = idx + CW'(1);
  assign im1 = idx - CW'(1);
  assign jm1 = j - CW'(1);
  assign jm2 = j - CW'(2);
  assign dm1 = depth - CW'(1);
  assign shift = (j != '0) && (trd.start > cur.start);
  assign last_i = (ip1 >= count);
  assign emit_go = (state == S_EMIT) && (!obuf_v || out_ch.ready);

  // Write ports and read addresses
  always_comb begin
    t_we = 1'b0; t_wa = count[AW-1:0];
    t_wd = '{id: in_ch.data.task_id, start: in_ch.data.start_minute,
             dur: in_ch.data.duration};
    p_we = 1'b0; p_wa = depth[AW-1:0]; p_wd = '{id: cur.id, remain: cur.dur - gap};
    traddr = idx[AW-1:0]; praddr = dm1[AW-1:0];
    case (state)
      S_LOAD: t_we = in_xfer && (count < CW'(MAX_TASKS));
      S_SCUR: traddr = im1[AW-1:0];
      S_SCMP: begin
        t_we = 1'b1; t_wa = j[AW-1:0];
        if (shift) begin
          t_wd = trd; traddr = jm2[AW-1:0];
        end else begin
          t_wd = cur;
        end
      end
      S_RCUR: traddr = ip1[AW-1:0];
      S_REVAL: p_we = !last_i && (cur.dur > gap);
      S_RCHK: begin
        p_we = prd.remain > spare;
        p_wa = dm1[AW-1:0];
        p_wd = '{id: prd.id, remain: prd.remain - spare};
      end
      default: ;
    endcase
  end

  // Control sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; ret <= S_LOAD; count <= '0; depth <= '0; idx <= '0; j <= '0;
      obuf_v <= 1'b0;
    end else begin
      // hold the result until its transfer, then load the next one
      if (emit_go) begin
        obuf_v <= 1'b1; obuf <= '{id: eid, last: elast};
      end else if (out_ch.ready) begin
        obuf_v <= 1'b0;
      end
      case (state)
        S_LOAD: if (in_xfer) begin
          if (count < CW'(MAX_TASKS)) count <= count + CW'(1);
          if (in_ch.data.last_task) begin
            idx <= CW'(1); depth <= '0; state <= S_SRD;
          end
        end
        // insertion sort: read the entry to insert
        S_SRD: begin
          if (idx >= count) begin
            idx <= '0; state <= S_RRD;
          end else begin
            state <= S_SCUR;
          end
        end
        S_SCUR: begin cur <= trd; j <= idx; state <= S_SCMP; end
        // shift later starts up, then drop the entry in place
        S_SCMP: begin
          if (shift) begin
            j <= jm1;
          end else begin
            idx <= ip1; state <= S_SRD;
          end
        end
        // schedule walk: fetch the task and its successor
        S_RRD: state <= (idx >= count) ? S_DRD : S_RCUR;
        S_RCUR: begin cur <= trd; state <= S_RNX; end
        S_RNX: begin tnext <= trd; state <= S_REVAL; end
        S_REVAL: begin
          idx <= ip1;
          if (last_i) begin
            eid <= cur.id; elast <= (depth == '0); ret <= S_RRD; state <= S_EMIT;
          end else if (cur.dur == gap) begin
            eid <= cur.id; elast <= 1'b0; ret <= S_RRD; state <= S_EMIT;
          end else if (cur.dur > gap) begin
            depth <= depth + CW'(1); state <= S_RRD;
          end else begin
            spare <= gap - cur.dur;
            eid <= cur.id; elast <= 1'b0; ret <= S_RPOP; state <= S_EMIT;
          end
        end
        // resume paused tasks from the top with the spare minutes
        S_RPOP: state <= (spare != '0 && depth != '0) ? S_RCHK : S_RRD;
        S_RCHK: begin
          if (prd.remain > spare) begin
            spare <= '0; state <= S_RRD;
          end else begin
            spare <= spare - prd.remain;
            eid <= prd.id; elast <= 1'b0; depth <= dm1;
            ret <= S_RPOP; state <= S_EMIT;
          end
        end
        S_EMIT: if (emit_go) state <= ret;
        // drain the stack top first, then clear the set
        S_DRD: begin
          if (depth == '0) begin
            count <= '0; state <= S_LOAD;
          end else begin
            state <= S_DCHK;
          end
        end
        S_DCHK: begin
          eid <= prd.id; elast <= (depth == CW'(1)); depth <= dm1;
          ret <= S_DRD; state <= S_EMIT;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lpco_pkg::*;

  localparam int TableDepth = MaxTasksDef;
  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 300;

  typedef struct {
    item_t      it;
    bit         chk;
    logic [5:0] want_id;
  } stim_t;

  logic clk;
  logic rst;

  lpco_in_if  in_ch();
  lpco_out_if out_ch();

  lifo_preemptive_completion_order_top dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  stim_t   task_stream[$];
  done_t   done_q[$];
  task_t   sched_tbl[TableDepth];
  paused_t paused_stk[TableDepth];
  int      sched_cnt;
  int      send_idx;
  int      fails;
  int      sets_run;
  int      results_seen;
  int      cycles;
  int      hold_left;
  bit      hold_done;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Append one expected completion
  function automatic void expect_done(logic [IdW-1:0] id);
    done_t d;
    d = '{id: id, last: 1'b0};
    done_q = {done_q, d};
  endfunction

  // Work out the completion order of a set once its closing task arrives
  function automatic void schedule_task(stim_t s);
    task_t cur;
    int    i, j, gap, rem, spare, depth, first;
    first = done_q.size();
    if (sched_cnt < TableDepth) begin
      sched_tbl[sched_cnt] = '{id: s.it.task_id, start: s.it.start_minute,
                               dur: s.it.duration};
      sched_cnt++;
    end
    if (!s.it.last_task) return;
    // stable insertion sort on start minute
    for (i = 1; i < sched_cnt; i++) begin
      cur = sched_tbl[i];
      j = i;
      while (j > 0 && sched_tbl[j-1].start > cur.start) begin
        sched_tbl[j] = sched_tbl[j-1];
        j--;
      end
      sched_tbl[j] = cur;
    end
    depth = 0;
    for (i = 0; i < sched_cnt; i++) begin
      if (i + 1 < sched_cnt) begin
        gap = int'(sched_tbl[i+1].start) - int'(sched_tbl[i].start);
        rem = int'(sched_tbl[i].dur);
        if (rem == gap) begin
          expect_done(sched_tbl[i].id);
        end else if (rem > gap) begin
          paused_stk[depth] = '{id: sched_tbl[i].id, remain: MinW'(rem - gap)};
          depth++;
        end else begin
          spare = gap - rem;
          expect_done(sched_tbl[i].id);
          // resume paused tasks from the top with the spare minutes
          while (spare > 0 && depth > 0) begin
            if (int'(paused_stk[depth-1].remain) > spare) begin
              paused_stk[depth-1].remain = MinW'(int'(paused_stk[depth-1].remain) - spare);
              spare = 0;
            end else begin
              spare -= int'(paused_stk[depth-1].remain);
              expect_done(paused_stk[depth-1].id);
              depth--;
            end
          end
        end
      end else begin
        expect_done(sched_tbl[i].id);
      end
    end
    // drain the stack top first
    while (depth > 0) begin
      expect_done(paused_stk[depth-1].id);
      depth--;
    end
    if (done_q.size() > first) done_q[done_q.size()-1].last = 1'b1;
    if (s.chk && (done_q.size() != first + 1 || done_q[first].id != s.want_id)) begin
      $error("directed set: done_id expected %0d alone, predicted otherwise", s.want_id);
      fails++;
    end
    sched_cnt = 0;
    sets_run++;
  endfunction

  function automatic void add_task(int id, int start, int dur, bit last,
                                   bit chk = 1'b0, int want = 0);
    stim_t s;
    s.it = '{task_id: IdW'(id), start_minute: MinW'(start), duration: MinW'(dur),
             last_task: last};
    s.chk = chk;
    s.want_id = 6'(want);
    task_stream = {task_stream, s};
  endfunction

  // Build the stimulus: directed rows first, then random sets
  initial begin
    int n, base, k;
    bit full_done;
    // single-task sets at the field extremes
    add_task(0, 0, 1, 1, 1, 0);
    add_task(63, 1439, 1439, 1, 1, 63);
    add_task(5, 200, 0, 1, 1, 5);
    add_task(42, 2047, 2047, 1, 1, 42);
    // overrun then exact fit of the final task
    add_task(1, 0, 10, 0);
    add_task(2, 5, 5, 1);
    // equal starts keep arrival order
    add_task(3, 100, 1, 0);
    add_task(4, 100, 1, 0);
    add_task(5, 100, 50, 1);
    // exact fit into the gap
    add_task(6, 0, 10, 0);
    add_task(7, 10, 3, 1);
    // early finish resumes a paused task; arrival out of order
    add_task(11, 1000, 5, 0);
    add_task(8, 0, 20, 0);
    add_task(12, 0, 3, 0);
    add_task(9, 5, 2, 0);
    add_task(10, 30, 1, 1);
    // alternating bit patterns
    add_task(21, 'h555, 'h2aa, 0);
    add_task(42, 'h2aa, 'h555, 0);
    add_task(63, 'h7ff, 0, 1);
    // random sets, one of them overflowing the table
    full_done = 1'b0;
    while (task_stream.size() < 276) begin
      if (!full_done && task_stream.size() > 120) begin
        n = TableDepth + 2;
        full_done = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        n = $urandom_range(24, 9);
      end else begin
        n = $urandom_range(6, 1);
      end
      base = $urandom_range(1900);
      for (k = 0; k < n; k++) begin
        add_task($urandom_range(63),
                 ($urandom_range(7) == 0) ? $urandom_range(2047) : base + $urandom_range(60),
                 ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(40),
                 k == n - 1);
      end
    end
  end

  // Reset and initial drive
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: offer tasks, record each transfer for prediction
  always @(posedge clk) begin
    int pct;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        schedule_task(task_stream[send_idx]);
        send_idx++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        pct = (send_idx < 100) ? 28 : (send_idx < 200) ? 64 : 0;
        if (send_idx < task_stream.size() && $urandom_range(99) >= pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= task_stream[send_idx].it;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off of the receiver while the sender keeps offering
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 400;
      end else if (hold_left > 0) begin
        hold_left--;
      end
    end
  end

  // Receiver: check each completion transfer, stall at random
  always @(posedge clk) begin
    int pct;
    done_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (done_q.size() == 0) begin
          $error("done transfer with nothing expected: id %0d", out_ch.data.id);
          fails++;
        end else begin
          want = done_q.pop_front();
          if (out_ch.data.id !== want.id) begin
            $error("done_id expected %0d actual %0d", want.id, out_ch.data.id);
            fails++;
          end
          if (out_ch.data.last !== want.last) begin
            $error("done_last expected %0d actual %0d", want.last, out_ch.data.last);
            fails++;
          end
        end
      end
      pct = (send_idx < 100) ? 64 : (send_idx < 200) ? 28 : 0;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL lifo_preemptive_completion_order_top");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (!rst);
    wait (task_stream.size() > 0 && send_idx == task_stream.size() && done_q.size() == 0);
    repeat (TailCycles) @(posedge clk);
    $display("Ran %0d tasks in %0d sets, %0d completions checked, incl. a table overflow",
             send_idx, sets_run, results_seen);
    if (fails == 0 && done_q.size() == 0) begin
      $display("PASS lifo_preemptive_completion_order_top");
    end else begin
      $display("FAIL lifo_preemptive_completion_order_top");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lpco_pkg.sv
rtl/lpco_if.sv
rtl/lifo_preemptive_completion_order_top.sv
tb/sv/tb.sv
